FILE: rtl/gne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_pkg
// Shared constants and types for the group normalisation engine.
// ----------------------------------------------------------------------------
package gne_pkg;

   localparam int MAX_GROUP = 1024;
   localparam int ADDR_W    = $clog2(MAX_GROUP);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = SAMPLE_W + CNT_W - 1;
   localparam int SQ_W      = 2 * SAMPLE_W + CNT_W - 1;
   localparam int EPS_W     = 16;
   localparam int DW        = 64;
   localparam int MB_W      = 32;

   typedef enum logic [1:0] {
      KIND_LOAD     = 2'd0,
      KIND_LOAD_END = 2'd1,
      KIND_READ     = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic signed [SAMPLE_W-1:0]  sample;
      logic signed [15:0]          scale;
      logic signed [15:0]          bias;
   } item_type;

endpackage

FILE: rtl/gne_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_front
// Accepts transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module gne_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic signed [15:0]  req_sample_value,
   input  logic                req_group_end,
   input  logic signed [15:0]  req_group_scale,
   input  logic signed [15:0]  req_group_bias,
   output logic                q_valid,
   output gne_pkg::item_type   q_item,
   input  logic                q_pop
);

   gne_pkg::item_type entry_ff [2];
   gne_pkg::item_type new_item;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   always_comb begin
      if (req_action) begin
         new_item.kind = gne_pkg::KIND_READ;
      end else if (req_group_end) begin
         new_item.kind = gne_pkg::KIND_LOAD_END;
      end else begin
         new_item.kind = gne_pkg::KIND_LOAD;
      end
      new_item.sample = req_sample_value;
      new_item.scale  = req_group_scale;
      new_item.bias   = req_group_bias;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> req_stall)
      else $error("full queue not stalling");
`endif

endmodule

FILE: rtl/gne_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gne_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gne_pkg::DW-1:0]     op_a,
   input  logic [gne_pkg::MB_W-1:0]   op_b,
   output logic                       done,
   output logic [gne_pkg::DW-1:0]     product
);

   localparam int CW = $clog2(gne_pkg::MB_W + 1);

   logic [gne_pkg::DW-1:0]   a_ff, a_in;
   logic [gne_pkg::MB_W-1:0] b_ff, b_in;
   logic [gne_pkg::DW-1:0]   acc_ff, acc_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = op_a;
         b_in   = op_b;
         acc_in = '0;
         cnt_in = CW'(gne_pkg::MB_W);
      end else if (cnt_ff != '0) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in    = {a_ff[gne_pkg::DW-2:0], 1'b0};
         b_in    = {1'b0, b_ff[gne_pkg::MB_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0))
      else $error("multiplier done while running");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (cnt_ff == '0))
      else $error("multiplier started while busy");
   a_done_after: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(cnt_ff == CW'(1)))
      else $error("multiplier done out of sequence");
`endif

endmodule

FILE: rtl/gne_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gne_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [gne_pkg::DW-1:0] numer,
   input  logic [gne_pkg::DW-1:0] denom,
   output logic                   done,
   output logic [gne_pkg::DW-1:0] quotient,
   output logic [gne_pkg::DW-1:0] remainder
);

   localparam int CW = $clog2(gne_pkg::DW + 1);

   logic [gne_pkg::DW-1:0] num_ff, num_in;
   logic [gne_pkg::DW-1:0] den_ff, den_in;
   logic [gne_pkg::DW-1:0] rem_ff, rem_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [gne_pkg::DW:0]   rem_sh;
   logic [gne_pkg::DW:0]   rem_sub;
   logic                   ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[gne_pkg::DW-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge      = (rem_sh >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = numer;
         den_in = denom;
         rem_in = '0;
         cnt_in = CW'(gne_pkg::DW);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? rem_sub[gne_pkg::DW-1:0] : rem_sh[gne_pkg::DW-1:0];
         num_in  = {num_ff[gne_pkg::DW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0))
      else $error("divider done while running");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (cnt_ff == '0))
      else $error("divider started while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < den_ff))
      else $error("remainder not below divisor");
`endif

endmodule

FILE: rtl/gne_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_back
// Executes queued transactions: sample store, running sums, group statistics
// sequence and the output register.
// ----------------------------------------------------------------------------
module gne_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  gne_pkg::item_type                 q_item,
   output logic                              q_pop,
   input  logic [gne_pkg::EPS_W-1:0]         epsilon,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [gne_pkg::SAMPLE_W-1:0] rsp_result_value,
   output logic                              rsp_result_last,
   output logic                              rsp_saturated
);

   localparam int DW  = gne_pkg::DW;
   localparam int SW  = gne_pkg::SAMPLE_W;
   localparam int CW  = gne_pkg::CNT_W;
   localparam int AW  = gne_pkg::ADDR_W;
   localparam int MW  = gne_pkg::MB_W;
   localparam logic signed [DW-1:0] HI_LIM = DW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [DW-1:0] LO_LIM = -HI_LIM - DW'(1);

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_RD   = 11'b00000000010,
      S_OUT  = 11'b00000000100,
      S_NQ   = 11'b00000001000,
      S_SS   = 11'b00000010000,
      S_DV   = 11'b00000100000,
      S_RC   = 11'b00001000000,
      S_SQ   = 11'b00010000000,
      S_GN   = 11'b00100000000,
      S_SG   = 11'b01000000000,
      S_OF   = 11'b10000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [CW-1:0]              rptr_ff, rptr_in;
   logic signed [gne_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [gne_pkg::SQ_W-1:0]   sq_ff, sq_in;
   logic signed [31:0]         gain_ff, gain_in;
   logic signed [31:0]         off_ff, off_in;
   logic                       rdy_ff, rdy_in;
   logic signed [15:0]         scale_ff, scale_in;
   logic signed [15:0]         bias_ff, bias_in;
   logic                       busy_ff, busy_in;
   logic [DW-1:0]              tmp_ff, tmp_in;
   logic [31:0]                root_ff, root_in;
   logic [4:0]                 bit_ff, bit_in;
   logic                       neg_ff, neg_in;
   logic                       last_ff, last_in;
   logic signed [47:0]         prod_ff, prod_in;
   logic                       ov_ff, ov_in;
   logic signed [SW-1:0]       ov_val_ff, ov_val_in;
   logic                       ov_last_ff, ov_last_in;
   logic                       ov_sat_ff, ov_sat_in;

   logic signed [SW-1:0]       mem [gne_pkg::MAX_GROUP];
   logic signed [SW-1:0]       rd_data_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic                       mem_re;

   logic                       mul_start, mul_done;
   logic [DW-1:0]              mul_a, mul_res;
   logic [MW-1:0]              mul_b;
   logic                       div_start, div_done;
   logic [DW-1:0]              div_num, div_den, div_quo, div_rem;

   logic [CW-1:0]              base_cnt;
   logic signed [gne_pkg::SUM_W-1:0] base_sum;
   logic [gne_pkg::SQ_W-1:0]   base_sq;
   logic signed [31:0]         sample_sq;
   logic [gne_pkg::SUM_W-1:0]  sum_mag;
   logic [31:0]                gain_mag;
   logic [31:0]                trial;
   logic [DW-1:0]              trial_sq;
   logic [2*CW-1:0]            cnt_sq;
   logic signed [45:0]         gs_prod;
   logic signed [45:0]         gs_round;
   logic signed [DW-1:0]       sg_signed;
   logic signed [DW-1:0]       num_s;
   logic [DW-1:0]              vsum;
   logic signed [DW-1:0]       qv;
   logic signed [DW-1:0]       acc;
   logic signed [DW-1:0]       yv;
   logic                       out_free;

   gne_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_res)
   );

   gne_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer     (div_num),
      .denom     (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      base_cnt  = rdy_ff ? '0 : cnt_ff;
      base_sum  = rdy_ff ? '0 : sum_ff;
      base_sq   = rdy_ff ? '0 : sq_ff;
      sample_sq = q_item.sample * q_item.sample;
      sum_mag   = sum_ff[gne_pkg::SUM_W-1] ? gne_pkg::SUM_W'(-sum_ff) : sum_ff;
      gain_mag  = gain_ff[31] ? 32'(-gain_ff) : gain_ff;
      trial     = root_ff | (32'd1 << bit_ff);
      trial_sq  = DW'(trial) * DW'(trial);
      cnt_sq    = (2*CW)'(cnt_ff) * (2*CW)'(cnt_ff);
      gs_prod   = $signed({1'b0, root_ff[28:0]}) * scale_ff;
      gs_round  = (gs_prod + 46'sd32768) >>> 16;
      sg_signed = neg_ff ? -$signed(mul_res) : $signed(mul_res);
      num_s     = (sg_signed <<< 1) + $signed(DW'(cnt_ff) << 12);
      vsum      = div_quo + DW'(epsilon);
      qv        = neg_ff ? -$signed(div_quo + DW'(div_rem != '0)) : $signed(div_quo);
      acc       = DW'(prod_ff) + ($signed(DW'(off_ff)) <<< 12);
      yv        = (acc + 64'sd32768) >>> 16;
      out_free  = !ov_ff || !rsp_stall;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_num = '0;
      div_den = '0;
      unique case (state_ff)
         S_NQ: begin
            mul_a = DW'(sq_ff);
            mul_b = MW'(cnt_ff);
         end
         S_SS: begin
            mul_a = DW'(sum_mag);
            mul_b = MW'(sum_mag);
         end
         S_SG: begin
            mul_a = DW'(sum_mag);
            mul_b = gain_mag;
         end
         S_DV: begin
            div_num = tmp_ff;
            div_den = DW'(cnt_sq);
         end
         S_RC: begin
            div_num = DW'(1) << 56;
            div_den = tmp_ff;
         end
         S_OF: begin
            div_num = tmp_ff;
            div_den = DW'(cnt_ff) << 13;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rptr_in    = rptr_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      gain_in    = gain_ff;
      off_in     = off_ff;
      rdy_in     = rdy_ff;
      scale_in   = scale_ff;
      bias_in    = bias_ff;
      busy_in    = busy_ff;
      tmp_in     = tmp_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      neg_in     = neg_ff;
      last_in    = last_ff;
      prod_in    = prod_ff;
      ov_in      = ov_ff && rsp_stall;
      ov_val_in  = ov_val_ff;
      ov_last_in = ov_last_ff;
      ov_sat_in  = ov_sat_ff;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = base_cnt[AW-1:0];
      mem_re     = 1'b0;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.kind == gne_pkg::KIND_READ) begin
                  if (rdy_ff && (rptr_ff < cnt_ff)) begin
                     mem_re   = 1'b1;
                     last_in  = ((rptr_ff + 1'b1) == cnt_ff);
                     rptr_in  = rptr_ff + 1'b1;
                     state_in = S_RD;
                  end
               end else begin
                  cnt_in = base_cnt;
                  sum_in = base_sum;
                  sq_in  = base_sq;
                  if (rdy_ff) begin
                     rptr_in = '0;
                     rdy_in  = 1'b0;
                  end
                  if (base_cnt < CW'(gne_pkg::MAX_GROUP)) begin
                     mem_we = 1'b1;
                     cnt_in = base_cnt + 1'b1;
                     sum_in = base_sum + gne_pkg::SUM_W'(q_item.sample);
                     sq_in  = base_sq + gne_pkg::SQ_W'(unsigned'(sample_sq));
                  end
                  if (q_item.kind == gne_pkg::KIND_LOAD_END && cnt_in != '0) begin
                     scale_in = q_item.scale;
                     bias_in  = q_item.bias;
                     state_in = S_NQ;
                  end
               end
            end
         end
         S_RD: begin
            prod_in  = rd_data_ff * gain_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               ov_in      = 1'b1;
               ov_last_in = last_ff;
               if (yv > HI_LIM) begin
                  ov_val_in = SW'(HI_LIM);
                  ov_sat_in = 1'b1;
               end else if (yv < LO_LIM) begin
                  ov_val_in = SW'(LO_LIM);
                  ov_sat_in = 1'b1;
               end else begin
                  ov_val_in = SW'(yv);
                  ov_sat_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         S_NQ: begin
            if (!busy_ff) begin
               mul_start = 1'b1;
               busy_in   = 1'b1;
            end else if (mul_done) begin
               busy_in  = 1'b0;
               tmp_in   = mul_res;
               state_in = S_SS;
            end
         end
         S_SS: begin
            if (!busy_ff) begin
               mul_start = 1'b1;
               busy_in   = 1'b1;
            end else if (mul_done) begin
               busy_in  = 1'b0;
               tmp_in   = tmp_ff - mul_res;
               state_in = S_DV;
            end
         end
         S_DV: begin
            if (!busy_ff) begin
               div_start = 1'b1;
               busy_in   = 1'b1;
            end else if (div_done) begin
               busy_in  = 1'b0;
               tmp_in   = (vsum == '0) ? DW'(1) : vsum;
               state_in = S_RC;
            end
         end
         S_RC: begin
            if (!busy_ff) begin
               div_start = 1'b1;
               busy_in   = 1'b1;
            end else if (div_done) begin
               busy_in  = 1'b0;
               tmp_in   = div_quo;
               root_in  = '0;
               bit_in   = 5'd31;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (trial_sq <= tmp_ff) begin
               root_in = trial;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = S_GN;
            end
         end
         S_GN: begin
            gain_in  = 32'(gs_round);
            state_in = S_SG;
         end
         S_SG: begin
            if (!busy_ff) begin
               mul_start = 1'b1;
               busy_in   = 1'b1;
               neg_in    = sum_ff[gne_pkg::SUM_W-1] ^ gain_ff[31];
            end else if (mul_done) begin
               busy_in  = 1'b0;
               neg_in   = num_s[DW-1];
               tmp_in   = num_s[DW-1] ? DW'(-num_s) : DW'(num_s);
               state_in = S_OF;
            end
         end
         S_OF: begin
            if (!busy_ff) begin
               div_start = 1'b1;
               busy_in   = 1'b1;
            end else if (div_done) begin
               busy_in  = 1'b0;
               off_in   = 32'(($signed(DW'(bias_ff)) <<< 4) - qv);
               rdy_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rptr_ff  <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         gain_ff  <= '0;
         off_ff   <= '0;
         rdy_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rptr_ff  <= rptr_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         gain_ff  <= gain_in;
         off_ff   <= off_in;
         rdy_ff   <= rdy_in;
         busy_ff  <= busy_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      scale_ff   <= scale_in;
      bias_ff    <= bias_in;
      tmp_ff     <= tmp_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      neg_ff     <= neg_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      ov_val_ff  <= ov_val_in;
      ov_last_ff <= ov_last_in;
      ov_sat_ff  <= ov_sat_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= q_item.sample;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rptr_ff[AW-1:0]];
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_result_value = ov_val_ff;
   assign rsp_result_last  = ov_last_ff;
   assign rsp_saturated    = ov_sat_ff;

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> ov_ff)
      else $error("result dropped under stall");
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(gne_pkg::MAX_GROUP))
      else $error("load count beyond store depth");
   a_rptr: assert property (@(posedge clock) disable iff (reset) rptr_ff <= cnt_ff)
      else $error("read pointer past load count");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE))
      else $error("queue popped while busy");
   a_units: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("two arithmetic units started together");
`endif

endmodule

FILE: rtl/group_norm_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_norm_engine_unit
// Group normalisation of Q8.8 samples with per-group Q4.12 gain and Q8.8 bias.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: action 0 loads a sample, action 1 reads the
//   next normalised result. The load with group_end set closes the group and
//   supplies its scale and bias. rsp_* returns one result per useful read;
//   reads before the group is closed or past its last sample return nothing.
//   csr_wr_en / csr_wr_data write epsilon; write only while the block is idle.
//   Both channels use valid/stall; a transaction moves when valid is high and
//   stall is low. A two-entry queue sits behind req_stall.
//   Flow: a plain load executes directly from idle; a read passes through the
//   store read, the multiply, and the round and saturate step. Closing a
//   group runs the statistics sequence on the shared shift-add multiplier
//   (three passes), the restoring divider (three passes) and a 32-step root
//   search, during which further transactions queue.
//   Reset (synchronous) clears counts, sums, flags and sets epsilon to 1.
//   A stalled result holds in the output register; the back end then waits.
// ----------------------------------------------------------------------------
module group_norm_engine_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic signed [15:0]  req_sample_value,
   input  logic                req_group_end,
   input  logic signed [15:0]  req_group_scale,
   input  logic signed [15:0]  req_group_bias,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_result_value,
   output logic                rsp_result_last,
   output logic                rsp_saturated,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   logic [gne_pkg::EPS_W-1:0] eps_ff, eps_in;
   logic                      q_valid;
   logic                      q_pop;
   gne_pkg::item_type         q_item;

   assign eps_in = csr_wr_en ? csr_wr_data : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= gne_pkg::EPS_W'(1);
      end else begin
         eps_ff <= eps_in;
      end
   end

   gne_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_sample_value (req_sample_value),
      .req_group_end    (req_group_end),
      .req_group_scale  (req_group_scale),
      .req_group_bias   (req_group_bias),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   gne_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .epsilon          (eps_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_last  (rsp_result_last),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

FILE: tb/group_norm_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_norm_engine_unit_tb
// Self-checking bench for the group normalisation engine. Load and read
// transactions come from a queue. A bit-exact predictor of the group
// statistics and the normalised outputs sits beside the block. Each returned
// result is checked field by field. Random idling runs on both channels, and
// epsilon changes between phases.
// ----------------------------------------------------------------------------
module group_norm_engine_unit_tb;

   localparam int STORE_DEPTH = 1024;
   localparam int SETTLE      = 400;

   typedef struct {
      logic               action;
      logic signed [15:0] sample;
      logic               group_end;
      logic signed [15:0] scale;
      logic signed [15:0] bias;
   } norm_txn_type;

   typedef struct {
      logic signed [15:0] value;
      logic               last;
      logic               sat;
   } norm_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = 1'b0;
   logic signed [15:0] req_sample_value = '0;
   logic               req_group_end = 1'b0;
   logic signed [15:0] req_group_scale = '0;
   logic signed [15:0] req_group_bias = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_result_value;
   logic               rsp_result_last;
   logic               rsp_saturated;
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;

   norm_txn_type pending_txns[$];
   norm_out_type expected_outs[$];
   norm_txn_type cur_txn;
   bit        accepted = 1'b0;
   bit        no_idle = 1'b0;
   int        fail_count = 0;

   // predictor state
   logic signed [15:0] store_mem[STORE_DEPTH];
   longint             n_loaded, rd_ptr, sum_acc;
   longint unsigned    sq_acc;
   int                 gain_q16, offset_q12;
   bit                 stats_ok;
   longint unsigned    eps_val;

   group_norm_engine_unit dut (.*);

   always #2 clock = ~clock;

   function automatic longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   function automatic longint round_div(longint num, longint den);
      return floor_div(2 * num + den, 2 * den);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned q);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= q) r = t;
      end
      return r;
   endfunction

   task automatic close_group_stats(longint scale, longint bias);
      longint unsigned n, mag, spread, v, r;
      longint g;
      n = n_loaded;
      mag = (sum_acc < 0) ? -sum_acc : sum_acc;
      spread = n * sq_acc - mag * mag;
      v = spread / (n * n) + eps_val;
      if (v == 0) v = 1;
      r = int_sqrt((64'd1 << 56) / v);
      g = round_div(longint'(r) * scale, 65536);
      gain_q16 = int'(g);
      offset_q12 = int'(bias * 16 - round_div(sum_acc * g, longint'(n) * 4096));
      stats_ok = 1'b1;
   endtask

   task automatic predict_norm(norm_txn_type t);
      longint x, acc, y;
      norm_out_type o;
      if (!t.action) begin
         if (stats_ok) begin
            n_loaded = 0; rd_ptr = 0; sum_acc = 0; sq_acc = 0; stats_ok = 1'b0;
         end
         if (n_loaded < STORE_DEPTH) begin
            x = longint'(t.sample);
            store_mem[n_loaded] = t.sample;
            n_loaded++;
            sum_acc += x;
            sq_acc += longint'(x * x);
         end
         if (t.group_end && n_loaded > 0)
            close_group_stats(longint'(t.scale), longint'(t.bias));
      end else if (stats_ok && rd_ptr < n_loaded) begin
         x = longint'(store_mem[rd_ptr]);
         rd_ptr++;
         acc = x * longint'(gain_q16) + longint'(offset_q12) * 4096;
         y = round_div(acc, 65536);
         o.sat = 1'b0;
         if (y > 32767) begin
            y = 32767; o.sat = 1'b1;
         end else if (y < -32768) begin
            y = -32768; o.sat = 1'b1;
         end
         o.value = y[15:0];
         o.last = (rd_ptr == n_loaded);
         expected_outs.push_back(o);
      end
   endtask

   // monitor, then predict the transaction accepted at this edge
   always @(posedge clock) begin
      norm_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outs.size() == 0) begin
            $error("unexpected result value=%0d", rsp_result_value);
            fail_count++;
         end else begin
            e = expected_outs.pop_front();
            if (rsp_result_value !== e.value) begin
               $error("result_value expected %0d actual %0d", e.value, rsp_result_value);
               fail_count++;
            end
            if (rsp_result_last !== e.last) begin
               $error("result_last expected %0d actual %0d", e.last, rsp_result_last);
               fail_count++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated expected %0d actual %0d", e.sat, rsp_saturated);
               fail_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         predict_norm(cur_txn);
         accepted = 1'b1;
      end
   end

   // driver
   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 22);
      if (!reset && (!req_valid || accepted)) begin
         accepted = 1'b0;
         if (pending_txns.size() > 0 && (no_idle || $urandom_range(99) >= 22)) begin
            cur_txn = pending_txns.pop_front();
            req_action       <= cur_txn.action;
            req_sample_value <= cur_txn.sample;
            req_group_end    <= cur_txn.group_end;
            req_group_scale  <= cur_txn.scale;
            req_group_bias   <= cur_txn.bias;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic add_load(logic signed [15:0] s, logic e, logic signed [15:0] sc,
                           logic signed [15:0] b);
      norm_txn_type t;
      t.action = 1'b0; t.sample = s; t.group_end = e; t.scale = sc; t.bias = b;
      pending_txns.push_back(t);
   endtask

   task automatic add_reads(int count);
      norm_txn_type t;
      for (int i = 0; i < count; i++) begin
         t.action = 1'b1; t.sample = 16'($urandom); t.group_end = 1'($urandom);
         t.scale = 16'($urandom); t.bias = 16'($urandom);
         pending_txns.push_back(t);
      end
   endtask

   function automatic logic signed [15:0] rand_sample();
      logic [7:0] b;
      if ($urandom_range(1)) return 16'($urandom);
      b = 8'($urandom);
      return {{8{b[7]}}, b};
   endfunction

   task automatic add_random_group();
      int size;
      size = ($urandom_range(9) == 0) ? int'($urandom_range(64, 2))
                                      : int'($urandom_range(12, 1));
      if ($urandom_range(7) == 0) add_reads(1);
      for (int i = 0; i < size; i++)
         add_load(rand_sample(), i == size - 1, 16'($urandom), 16'($urandom));
      add_reads(int'($urandom_range(size + 1)));
   endtask

   task automatic drain_and_settle();
      while (pending_txns.size() != 0 || req_valid) @(posedge clock);
      while (expected_outs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [15:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      eps_val = 64'(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      n_loaded = 0; rd_ptr = 0; sum_acc = 0; sq_acc = 0;
      gain_q16 = 0; offset_q12 = 0; stats_ok = 1'b0; eps_val = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // early read, extremes, over-read
      add_reads(1);
      add_load(16'sh7fff, 1'b0, 16'sh0000, 16'sh0000);
      add_load(-16'sh8000, 1'b1, 16'sh7fff, -16'sh8000);
      add_reads(3);
      add_load(16'sh0100, 1'b0, 16'sh0000, 16'sh0000);
      add_load(-16'sh0100, 1'b1, -16'sh8000, 16'sh7fff);
      add_reads(2);
      drain_and_settle();

      // zero variance with zero epsilon, then new group before all reads
      write_epsilon(16'h0000);
      for (int i = 0; i < 4; i++) add_load(16'sh0100, i == 3, 16'sh1000, 16'sh0000);
      add_reads(4);
      for (int i = 0; i < 3; i++)
         add_load(rand_sample(), i == 2, 16'($urandom), 16'($urandom));
      add_reads(1);
      for (int i = 0; i < 2; i++)
         add_load(rand_sample(), i == 1, 16'($urandom), 16'($urandom));
      add_reads(3);
      drain_and_settle();

      // overfill the store
      write_epsilon(16'hffff);
      for (int i = 0; i < STORE_DEPTH + 2; i++)
         add_load(rand_sample(), i == STORE_DEPTH + 1, 16'($urandom), 16'($urandom));
      add_reads(4);
      drain_and_settle();

      no_idle = 1'b1;
      for (int i = 0; i < 6; i++) add_random_group();
      drain_and_settle();
      no_idle = 1'b0;

      write_epsilon(16'($urandom));
      while (pending_txns.size() < 30) add_random_group();
      drain_and_settle();

      write_epsilon(16'($urandom_range(15)));
      while (pending_txns.size() < 30) add_random_group();
      drain_and_settle();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("simulation failed");
      $finish;
   end

endmodule
